### rtl/dmbs_pkg.sv
`timescale 1ns / 1ps

package dmbs_pkg;

    localparam int IMAGE_MAX_WIDTH_DEF  = 256;
    localparam int IMAGE_MAX_HEIGHT_DEF = 256;

    localparam int COORD_W  = 11;
    localparam int SIZE_W   = 13;
    localparam int BRIGHT_W = 17;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SHIFT_X      = 3'd2;
    localparam logic [2:0] REG_SHIFT_Y      = 3'd3;
    localparam logic [2:0] REG_BRIGHTNESS   = 3'd4;

    typedef struct packed {
        logic                        is_load;
        logic signed [COORD_W-1:0]   ix;
        logic signed [COORD_W-1:0]   iy;
        logic [7:0]                  dx;
        logic [7:0]                  dy;
        logic                        single;
        logic signed [BRIGHT_W-1:0]  bright;
        logic [31:0]                 pixel;
    } t_qent;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [8:0] reg_val,
                                                   input logic [SIZE_W-1:0] max_size);
        logic [SIZE_W-1:0] v;
        v = SIZE_W'(reg_val);
        if (v == '0) begin
            v = SIZE_W'(1);
        end else if (v > max_size) begin
            v = max_size;
        end
        return v;
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_coord(input logic signed [COORD_W:0] c,
                                                      input logic [SIZE_W-1:0] n);
        logic [SIZE_W-1:0] r;
        if (c < 0) begin
            r = '0;
        end else if ($signed({1'b0, n}) <= $signed({{(SIZE_W-COORD_W){c[COORD_W]}}, c})) begin
            r = n - SIZE_W'(1);
        end else begin
            r = SIZE_W'(c);
        end
        return r;
    endfunction

    function automatic logic [7:0] sat8(input logic signed [BRIGHT_W+1:0] v);
        logic [7:0] r;
        if (v < 0) begin
            r = 8'd0;
        end else if (v > 255) begin
            r = 8'd255;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

### rtl/dmbs_front.sv
`timescale 1ns / 1ps

module dmbs_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_cmd,
    input  logic [55:0]                i_data,
    input  logic signed [23:0]         i_shift_x,
    input  logic signed [23:0]         i_shift_y,
    input  logic [7:0]                 i_level,
    output logic                       o_push,
    input  logic                       i_push_ready,
    output dmbs_pkg::t_qent            o_ent
);

    logic               r_valid;
    logic               r_cmd;
    logic [7:0]         r_px;
    logic [7:0]         r_py;
    logic [31:0]        r_pixel;
    logic signed [32:0] r_prod_x;
    logic signed [32:0] r_prod_y;
    logic signed [17:0] r_bright;

    logic signed [8:0]  d;
    logic signed [32:0] adj_x;
    logic signed [32:0] adj_y;
    logic signed [26:0] sx;
    logic signed [26:0] sy;
    logic signed [26:0] fx;
    logic signed [26:0] fy;
    logic               direct;

    assign d = $signed(9'({1'b0, i_data[55:48]}) - 9'd128);
    assign o_ready = !r_valid || i_push_ready;
    assign o_push = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_cmd    <= i_cmd;
            r_px     <= i_data[7:0];
            r_py     <= i_data[15:8];
            r_pixel  <= {i_data[23:16], i_data[31:24], i_data[39:32], i_data[47:40]};
            r_prod_x <= 33'(i_shift_x * d);
            r_prod_y <= 33'(i_shift_y * d);
            r_bright <= 18'(d * $signed({1'b0, i_level}));
        end
    end

    always_comb begin
        adj_x  = r_prod_x[32] ? r_prod_x + 33'sd127 : r_prod_x;
        adj_y  = r_prod_y[32] ? r_prod_y + 33'sd127 : r_prod_y;
        sx     = 27'(adj_x >>> 7);
        sy     = 27'(adj_y >>> 7);
        fx     = $signed({3'b000, r_px, 16'h0000}) - sx;
        fy     = $signed({3'b000, r_py, 16'h0000}) - sy;
        direct = (sx == '0) && (sy == '0);

        o_ent.is_load = !r_cmd;
        o_ent.pixel   = r_pixel;
        if (!r_cmd || direct) begin
            o_ent.ix     = $signed({{(dmbs_pkg::COORD_W-8){1'b0}}, r_px});
            o_ent.iy     = $signed({{(dmbs_pkg::COORD_W-8){1'b0}}, r_py});
            o_ent.dx     = 8'd0;
            o_ent.dy     = 8'd0;
            o_ent.bright = '0;
        end else begin
            o_ent.ix     = fx[26:16];
            o_ent.iy     = fy[26:16];
            o_ent.dx     = fx[15:8];
            o_ent.dy     = fy[15:8];
            o_ent.bright = r_bright[dmbs_pkg::BRIGHT_W-1:0];
        end
        o_ent.single = (o_ent.dx == 8'd0) && (o_ent.dy == 8'd0);
    end

endmodule

### rtl/dmbs_queue.sv
`timescale 1ns / 1ps

module dmbs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_push_ready,
    input  dmbs_pkg::t_qent i_ent,
    output logic            o_valid,
    input  logic            i_pop,
    output dmbs_pkg::t_qent o_ent
);

    localparam int PTR_W = $clog2(dmbs_pkg::QUEUE_DEPTH);

    dmbs_pkg::t_qent  r_buf [dmbs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [PTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_push_ready = r_count != (PTR_W+1)'(dmbs_pkg::QUEUE_DEPTH);
    assign o_valid      = r_count != '0;
    assign o_ent        = r_buf[r_rptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            r_count <= r_count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
        end
        if (do_push) begin
            r_buf[r_wptr] <= i_ent;
        end
    end

endmodule

### rtl/dmbs_back.sv
`timescale 1ns / 1ps

module dmbs_back #(
    parameter int IMAGE_MAX_WIDTH  = dmbs_pkg::IMAGE_MAX_WIDTH_DEF,
    parameter int IMAGE_MAX_HEIGHT = dmbs_pkg::IMAGE_MAX_HEIGHT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_pop,
    input  dmbs_pkg::t_qent i_q_ent,
    input  logic [8:0]      i_width,
    input  logic [8:0]      i_height,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_data
);

    localparam int DEPTH  = IMAGE_MAX_WIDTH * IMAGE_MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int OF_D   = 4;
    localparam int OF_W   = $clog2(OF_D);

    logic [31:0]       r_mem [DEPTH];
    logic [31:0]       r_rdata;

    logic              r_busy;
    dmbs_pkg::t_qent   r_cur;
    logic [1:0]        r_k;
    logic [OF_W:0]     r_inflight;

    logic              r_s1_valid;
    logic              r_s1_first;
    logic              r_s1_last;
    logic [16:0]       r_s1_w;
    logic signed [dmbs_pkg::BRIGHT_W-1:0] r_s1_bright;

    logic              r_s2_valid;
    logic              r_s2_first;
    logic              r_s2_last;
    logic [24:0]       r_s2_prod [4];
    logic signed [dmbs_pkg::BRIGHT_W-1:0] r_s2_bright;

    logic [24:0]       r_acc [4];
    logic              r_s3_valid;
    logic [24:0]       r_s3_sum [4];
    logic signed [dmbs_pkg::BRIGHT_W-1:0] r_s3_bright;

    logic [31:0]       r_of [OF_D];
    logic [OF_W-1:0]   r_of_w;
    logic [OF_W-1:0]   r_of_r;
    logic [OF_W:0]     r_of_count;

    logic              last_issue;
    logic              can_pop;
    logic              pop_sample;
    logic              out_xfer;
    logic              mem_rd;
    logic              mem_we;
    logic [ADDR_W-1:0] addr;
    logic [dmbs_pkg::SIZE_W-1:0] n_w;
    logic [dmbs_pkg::SIZE_W-1:0] n_h;
    logic [dmbs_pkg::SIZE_W-1:0] cx;
    logic [dmbs_pkg::SIZE_W-1:0] cy;
    logic [8:0]        wx;
    logic [8:0]        wy;
    logic [16:0]       w;
    logic [24:0]       sum [4];
    logic [31:0]       of_in;
    logic [7:0]        ch [4];

    assign last_issue = r_cur.is_load || r_cur.single || (r_k == 2'd3);
    assign can_pop    = !r_busy || last_issue;
    assign o_q_pop    = can_pop && i_q_valid &&
                        (i_q_ent.is_load || (r_inflight != (OF_W+1)'(OF_D)));
    assign pop_sample = o_q_pop && !i_q_ent.is_load;
    assign out_xfer   = o_valid && i_ready;
    assign o_valid    = r_of_count != '0;
    assign o_data     = r_of[r_of_r];

    always_comb begin
        n_w = dmbs_pkg::eff_size(i_width, dmbs_pkg::SIZE_W'(IMAGE_MAX_WIDTH));
        n_h = dmbs_pkg::eff_size(i_height, dmbs_pkg::SIZE_W'(IMAGE_MAX_HEIGHT));
        cx  = dmbs_pkg::clamp_coord($signed({r_cur.ix[dmbs_pkg::COORD_W-1], r_cur.ix}) +
                  $signed({{dmbs_pkg::COORD_W{1'b0}}, r_k[0]}), n_w);
        cy  = dmbs_pkg::clamp_coord($signed({r_cur.iy[dmbs_pkg::COORD_W-1], r_cur.iy}) +
                  $signed({{dmbs_pkg::COORD_W{1'b0}}, r_k[1]}), n_h);
        if (r_cur.is_load) begin
            addr   = ADDR_W'(int'(r_cur.iy) * IMAGE_MAX_WIDTH + int'(r_cur.ix));
            mem_we = r_busy && (int'(r_cur.ix) < IMAGE_MAX_WIDTH) &&
                     (int'(r_cur.iy) < IMAGE_MAX_HEIGHT);
        end else begin
            addr   = ADDR_W'(int'(cy) * IMAGE_MAX_WIDTH + int'(cx));
            mem_we = 1'b0;
        end
        mem_rd = r_busy && !r_cur.is_load;
        wx = r_k[0] ? {1'b0, r_cur.dx} : 9'd256 - {1'b0, r_cur.dx};
        wy = r_k[1] ? {1'b0, r_cur.dy} : 9'd256 - {1'b0, r_cur.dy};
        w  = 17'(wx * wy);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[addr] <= r_cur.pixel;
        end
        if (mem_rd) begin
            r_rdata <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_k        <= '0;
            r_inflight <= '0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy && last_issue) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_k <= r_k + 2'd1;
            end
            r_inflight <= r_inflight + (OF_W+1)'(pop_sample) - (OF_W+1)'(out_xfer);
        end
        if (o_q_pop) begin
            r_cur <= i_q_ent;
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            sum[c] = (r_s2_first ? 25'd0 : r_acc[c]) + r_s2_prod[c];
        end
        ch[0] = r_s3_sum[0][23:16];
        for (int c = 1; c < 4; c++) begin
            ch[c] = dmbs_pkg::sat8($signed({{(dmbs_pkg::BRIGHT_W-6){1'b0}}, r_s3_sum[c][23:16]})
                    + $signed({{2{r_s3_bright[dmbs_pkg::BRIGHT_W-1]}}, r_s3_bright}));
        end
        of_in = {ch[3], ch[2], ch[1], ch[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_of_w     <= '0;
            r_of_r     <= '0;
            r_of_count <= '0;
        end else begin
            r_s1_valid <= mem_rd;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid && r_s2_last;
            if (r_s3_valid) begin
                r_of_w <= r_of_w + OF_W'(1);
            end
            if (out_xfer) begin
                r_of_r <= r_of_r + OF_W'(1);
            end
            r_of_count <= r_of_count + (OF_W+1)'(r_s3_valid) - (OF_W+1)'(out_xfer);
        end
        r_s1_first  <= r_k == 2'd0;
        r_s1_last   <= last_issue;
        r_s1_w      <= w;
        r_s1_bright <= r_cur.bright;
        r_s2_first  <= r_s1_first;
        r_s2_last   <= r_s1_last;
        r_s2_bright <= r_s1_bright;
        for (int c = 0; c < 4; c++) begin
            r_s2_prod[c] <= 25'(r_rdata[8*(3-c) +: 8] * r_s1_w);
        end
        if (r_s2_valid) begin
            for (int c = 0; c < 4; c++) begin
                r_acc[c] <= sum[c];
            end
        end
        if (r_s2_valid && r_s2_last) begin
            for (int c = 0; c < 4; c++) begin
                r_s3_sum[c] <= sum[c];
            end
            r_s3_bright <= r_s2_bright;
        end
        if (r_s3_valid) begin
            r_of[r_of_w] <= of_in;
        end
    end

endmodule

### rtl/displacement_map_bilinear_sampler_top.sv
`timescale 1ns / 1ps

// Displacement-map bilinear sampler. Load transfers (tuser 0) write one ARGB pixel into the
// on-chip image memory and produce no output; sample transfers (tuser 1) produce one ARGB
// pixel. The front end takes one transfer per cycle while the queue has room and works out
// the displaced position, and a four-entry queue feeds the back end, which owns the
// single-ported image memory: a load is one memory write and a sample is four neighbour
// reads, one per cycle, or one read when the sample point falls on a whole pixel. The back
// end can take the next queue entry while it issues the last access of the current one.
// Pixels must be loaded before they are sampled. The user must write registers through
// the configuration channel only while the block is idle; the block does not enforce
// this itself.

module displacement_map_bilinear_sampler_top #(
    parameter int IMAGE_MAX_WIDTH  = dmbs_pkg::IMAGE_MAX_WIDTH_DEF,
    parameter int IMAGE_MAX_HEIGHT = dmbs_pkg::IMAGE_MAX_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pos_x, pos_y, src_alpha, src_red, src_green, src_blue, map_value
    input  logic [55:0] s_axis_tdata,
    // cmd
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_alpha, out_red, out_green, out_blue
    output logic [31:0] m_axis_tdata
);

    logic [8:0]         r_width;
    logic [8:0]         r_height;
    logic signed [23:0] r_shift_x;
    logic signed [23:0] r_shift_y;
    logic [7:0]         r_level;

    logic               push;
    logic               push_ready;
    dmbs_pkg::t_qent    fe_ent;
    logic               q_valid;
    logic               q_pop;
    dmbs_pkg::t_qent    q_ent;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= 9'd256;
            r_height  <= 9'd256;
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_level   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dmbs_pkg::REG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data[8:0];
                end
                dmbs_pkg::REG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data[8:0];
                end
                dmbs_pkg::REG_SHIFT_X: begin
                    r_shift_x <= i_cfg_data;
                end
                dmbs_pkg::REG_SHIFT_Y: begin
                    r_shift_y <= i_cfg_data;
                end
                dmbs_pkg::REG_BRIGHTNESS: begin
                    r_level <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    dmbs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (s_axis_tuser),
        .i_data       (s_axis_tdata),
        .i_shift_x    (r_shift_x),
        .i_shift_y    (r_shift_y),
        .i_level      (r_level),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_ent        (fe_ent)
    );

    dmbs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_ent        (fe_ent),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_ent        (q_ent)
    );

    dmbs_back #(
        .IMAGE_MAX_WIDTH  (IMAGE_MAX_WIDTH),
        .IMAGE_MAX_HEIGHT (IMAGE_MAX_HEIGHT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_ent   (q_ent),
        .i_width   (r_width),
        .i_height  (r_height),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata)
    );

endmodule

### tb/displacement_map_bilinear_sampler_top_tb.sv
`timescale 1ns / 1ps

module displacement_map_bilinear_sampler_top_tb;

    localparam bit         CMD_LOAD   = 1'b0;
    localparam bit         CMD_SAMPLE = 1'b1;
    localparam logic [2:0] REG_SPARE  = 3'd7;
    localparam int         CYCLE_LIMIT = 600000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [23:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    displacement_map_bilinear_sampler_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    logic [31:0]        image_store [0:65535];
    bit                 loaded [0:65535];
    logic [8:0]         width_reg;
    logic [8:0]         height_reg;
    logic signed [23:0] shift_x;
    logic signed [23:0] shift_y;
    logic [7:0]         gain;

    logic [31:0] pending_pixels[$];
    int          mismatches;
    int          samples_sent;
    int          loads_sent;
    int          pixels_checked;
    int          cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int eff_dim(logic [8:0] r);
        if (r == 0) return 1;
        if (r > 256) return 256;
        return int'(r);
    endfunction

    function automatic logic [31:0] fetch_pixel(longint x, longint y);
        longint w;
        longint h;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        if (x < 0) x = 0;
        if (x >= w) x = w - 1;
        if (y < 0) y = 0;
        if (y >= h) y = h - 1;
        return image_store[int'(x + y * 256)];
    endfunction

    function automatic int clip8(longint v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return int'(v);
    endfunction

    // Returns the pixel packed as on the output bus, alpha in the lowest byte.
    function automatic logic [31:0] displaced_pixel(int px, int py, int mv);
        longint d, sx, sy, fx, fy, fracx, fracy, ix, iy, acc, lift;
        longint dx1, dy1, dx2, dy2;
        logic [31:0] p0, p1, p2, p3;
        int ch [4];
        int sh;
        d = mv - 128;
        sx = (longint'(shift_x) * d) / 128;
        sy = (longint'(shift_y) * d) / 128;
        if (sx == 0 && sy == 0) begin
            p0 = fetch_pixel(px, py);
            return {p0[7:0], p0[15:8], p0[23:16], p0[31:24]};
        end
        fx = longint'(px) * 65536 - sx;
        fy = longint'(py) * 65536 - sy;
        fracx = fx & 64'hFFFF;
        fracy = fy & 64'hFFFF;
        ix = (fx - fracx) / 65536;
        iy = (fy - fracy) / 65536;
        dx1 = fracx >> 8;
        dy1 = fracy >> 8;
        dx2 = 256 - dx1;
        dy2 = 256 - dy1;
        p0 = fetch_pixel(ix, iy);
        p1 = fetch_pixel(ix + 1, iy);
        p2 = fetch_pixel(ix, iy + 1);
        p3 = fetch_pixel(ix + 1, iy + 1);
        for (int k = 0; k < 4; k++) begin
            sh = 24 - 8 * k;
            if (dx1 == 0 && dy1 == 0) begin
                ch[k] = int'((p0 >> sh) & 8'hFF);
            end else begin
                acc = longint'((p0 >> sh) & 8'hFF) * dx2 * dy2
                    + longint'((p1 >> sh) & 8'hFF) * dx1 * dy2
                    + longint'((p2 >> sh) & 8'hFF) * dx2 * dy1
                    + longint'((p3 >> sh) & 8'hFF) * dx1 * dy1;
                ch[k] = clip8(acc >> 16);
            end
        end
        if (gain != 0) begin
            lift = d * longint'(gain);
            for (int k = 1; k < 4; k++) ch[k] = clip8(ch[k] + lift);
        end
        return {ch[3][7:0], ch[2][7:0], ch[1][7:0], ch[0][7:0]};
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected pixel", int'(m_axis_tdata), 0);
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (m_axis_tdata[7:0] != want[7:0])
                    report_mismatch("alpha", m_axis_tdata[7:0], want[7:0]);
                if (m_axis_tdata[15:8] != want[15:8])
                    report_mismatch("red", m_axis_tdata[15:8], want[15:8]);
                if (m_axis_tdata[23:16] != want[23:16])
                    report_mismatch("green", m_axis_tdata[23:16], want[23:16]);
                if (m_axis_tdata[31:24] != want[31:24])
                    report_mismatch("blue", m_axis_tdata[31:24], want[31:24]);
            end
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(bit cmd, int px, int py, logic [31:0] argb, int mv);
        int gap;
        // Fields are eight bits wide on the bus, so positions past the edge wrap.
        px = px & 255;
        py = py & 255;
        mv = mv & 255;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {mv[7:0], argb[7:0], argb[15:8], argb[23:16], argb[31:24],
                          py[7:0], px[7:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        if (cmd == CMD_LOAD) begin
            image_store[px + py * 256] = argb;
            loaded[px + py * 256] = 1'b1;
            loads_sent++;
        end else begin
            pending_pixels.push_back(displaced_pixel(px, py, mv));
            samples_sent++;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            dmbs_pkg::REG_IMAGE_WIDTH:  width_reg  = val[8:0];
            dmbs_pkg::REG_IMAGE_HEIGHT: height_reg = val[8:0];
            dmbs_pkg::REG_SHIFT_X:      shift_x    = val;
            dmbs_pkg::REG_SHIFT_Y:      shift_y    = val;
            dmbs_pkg::REG_BRIGHTNESS:   gain       = val[7:0];
            default: ;
        endcase
    endtask

    task automatic configure(int w, int h, int sx, int sy, int lvl);
        write_reg(dmbs_pkg::REG_IMAGE_WIDTH, 24'(w));
        write_reg(dmbs_pkg::REG_IMAGE_HEIGHT, 24'(h));
        write_reg(dmbs_pkg::REG_SHIFT_X, 24'(sx));
        write_reg(dmbs_pkg::REG_SHIFT_Y, 24'(sy));
        write_reg(dmbs_pkg::REG_BRIGHTNESS, 24'(lvl));
    endtask

    // Every pixel that a sample may reach under the current size gets loaded first.
    task automatic load_image_area();
        for (int y = 0; y < eff_dim(height_reg); y++)
            for (int x = 0; x < eff_dim(width_reg); x++)
                if (!loaded[x + y * 256]) send_item(CMD_LOAD, x, y, $urandom, 0);
    endtask

    task automatic send_random_sample();
        int px;
        int py;
        int mv;
        if ($urandom_range(3) == 0) begin
            px = $urandom_range(255);
            py = $urandom_range(255);
        end else begin
            px = $urandom_range(eff_dim(width_reg) + 1);
            py = $urandom_range(eff_dim(height_reg) + 1);
        end
        case ($urandom_range(5))
            0: mv = 128;
            1: mv = ($urandom_range(1) != 0) ? 0 : 255;
            default: mv = $urandom_range(255);
        endcase
        send_item(CMD_SAMPLE, px, py, $urandom, mv);
    endtask

    function automatic int random_shift();
        case ($urandom_range(4))
            0: return 0;
            1: return int'($signed(24'($urandom)));
            2: return 65536 * ($urandom_range(8) - 4);
            default: return $urandom_range(0, 'h7FFFF) - 'h40000;
        endcase
    endfunction

    task automatic test_directed();
        configure(4, 4, 0, 0, 0);
        write_reg(REG_SPARE, 24'hFFFFFF);
        send_item(CMD_LOAD, 0, 0, 32'hFFFFFFFF, 0);
        send_item(CMD_LOAD, 3, 3, 32'h00000000, 255);
        load_image_area();
        send_item(CMD_SAMPLE, 0, 0, 0, 0);
        send_item(CMD_SAMPLE, 255, 255, 32'hFFFFFFFF, 255);
        send_item(CMD_SAMPLE, 2, 1, 0, 128);
        configure(4, 4, 24'sh7FFFFF, -24'sh800000, 255);
        send_item(CMD_SAMPLE, 1, 2, 0, 0);
        send_item(CMD_SAMPLE, 3, 0, 0, 255);
        send_item(CMD_SAMPLE, 2, 2, 0, 129);
        send_item(CMD_SAMPLE, 2, 2, 0, 127);
        configure(0, 511, 65536, -131072, 1);
        send_item(CMD_SAMPLE, 2, 3, 0, 0);
        send_item(CMD_SAMPLE, 1, 1, 0, 255);
        configure(4, 4, 32768, 16384, 0);
        send_item(CMD_SAMPLE, 1, 1, 0, 0);
        send_item(CMD_SAMPLE, 3, 3, 0, 200);
    endtask

    task automatic test_strip(int w, int h, int n);
        configure(w, h, random_shift(), random_shift(), $urandom_range(3) == 0 ? 255 : 0);
        load_image_area();
        repeat (n) send_random_sample();
    endtask

    task automatic test_random_settings(int settings, int n);
        repeat (settings) begin
            configure($urandom_range(3) == 0 ? $urandom_range(0, 20) : $urandom_range(1, 16),
                      $urandom_range(1, 16), random_shift(), random_shift(),
                      $urandom_range(1) != 0 ? 0 : $urandom_range(255));
            load_image_area();
            repeat (n) begin
                if ($urandom_range(9) == 0) send_item(CMD_LOAD, $urandom_range(eff_dim(width_reg) - 1),
                    $urandom_range(eff_dim(height_reg) - 1), $urandom, $urandom_range(255));
                else send_random_sample();
            end
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(8, 8, 40000, -70000, 3);
        load_image_area();
        hold_left = 300;
        repeat (30) send_random_sample();
        drain();
        repeat (20) send_random_sample();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        mismatches = 0;
        samples_sent = 0;
        loads_sent = 0;
        pixels_checked = 0;
        cycles = 0;
        hold_left = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        width_reg = 9'd256;
        height_reg = 9'd256;
        shift_x = '0;
        shift_y = '0;
        gain = '0;
        for (int a = 0; a < 65536; a++) begin
            image_store[a] = '0;
            loaded[a] = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_strip(300, 1, 80);
        test_strip(0, 256, 80);
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random_settings(3, 55);
        send_idle_pct = 77; recv_stall_pct = 0;  test_random_settings(3, 55);
        send_idle_pct = 0;  recv_stall_pct = 77; test_random_settings(3, 55);
        send_idle_pct = 23; recv_stall_pct = 23; test_random_settings(3, 55);
        test_backpressure();

        drain();
        repeat (40) @(posedge i_clk);
        $display("covered %0d pixel loads and %0d displaced samples, %0d pixels checked",
                 loads_sent, samples_sent, pixels_checked);
        $display("sizes from one pixel to full strips, shifts to both extremes, brightness gain");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### sim.f
rtl/dmbs_pkg.sv
rtl/dmbs_front.sv
rtl/dmbs_queue.sv
rtl/dmbs_back.sv
rtl/displacement_map_bilinear_sampler_top.sv
tb/displacement_map_bilinear_sampler_top_tb.sv
